>>> sv/csvfe_pkg.sv
// csvfe_pkg: types, codes and constants of the csv field extractor
// used by csv_field_extractor; no dependencies

package csvfe_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MASK_W      = 64;
	localparam int DATA_W      = 64;
	localparam int ADDR_W      = 6;

	localparam logic [MASK_W-1:0] COL_LIMIT = (MAX_COLUMNS >= MASK_W) ? {MASK_W{1'b1}} :
		((MASK_W'(1) << MAX_COLUMNS) - MASK_W'(1));

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_QUOTE = 8'd34;

	localparam logic [6:0] CNT_MAX  = 7'd127;
	localparam logic [6:0] COL_SAT  = 7'd63;
	localparam logic [6:0] SLOT_SAT = 7'd64;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_UNQUOTED   = 2'd0;
	localparam logic [1:0] ERR_LONE_QUOTE = 2'd1;
	localparam logic [1:0] ERR_UNTERM     = 2'd2;
	localparam logic [1:0] ERR_COUNT      = 2'd3;

	// register indexes
	localparam logic [2:0] REG_DELIM  = 3'd0;
	localparam logic [2:0] REG_QUOTE  = 3'd1;
	localparam logic [2:0] REG_SELALL = 3'd2;
	localparam logic [2:0] REG_MASK   = 3'd3;
	localparam logic [2:0] REG_EXPECT = 3'd4;

	typedef enum logic [5:0] {
		PH_START      = 6'b000001,
		PH_UNQUOTED   = 6'b000010,
		PH_QUOTED     = 6'b000100,
		PH_QUOTE_SEEN = 6'b001000,
		PH_DONE       = 6'b010000,
		PH_ERROR      = 6'b100000
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [6:0] col;
		logic [6:0] slot;
		logic       fis;
	} parse_st_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] field_byte;
		logic [5:0] source_column;
		logic [6:0] output_slot;
		logic       record_done;
		logic [1:0] error_code;
		logic       last_result;
	} result_t;

endpackage

>>> sv/csvfe_if.sv
// csvfe_if: valid/ready channels of the csv field extractor
// csvfe_in_if carries record bytes, csvfe_out_if carries results; no dependencies

interface csvfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] record_byte;
	logic       last_in_record;

	modport source (output valid, output record_byte, output last_in_record, input ready);
	modport sink (input valid, input record_byte, input last_in_record, output ready);
endinterface

interface csvfe_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] field_byte;
	logic [5:0] source_column;
	logic [6:0] output_slot;
	logic       record_done;
	logic [1:0] error_code;
	logic       last_result;

	modport source (output valid, output kind, output field_byte, output source_column,
		output output_slot, output record_done, output error_code, output last_result,
		input ready);
	modport sink (input valid, input kind, input field_byte, input source_column,
		input output_slot, input record_done, input error_code, input last_result,
		output ready);
endinterface

>>> sv/csv_field_extractor.sv
// csv_field_extractor: splits csv records into selected fields, one byte per word
// depends on csvfe_pkg and the channel interfaces in csvfe_if.sv
//
// Usage: record bytes enter on the bytes channel, the final byte of a record
// with last_in_record set. Each byte yields zero, one or two words on the
// results channel: content bytes, field ends, errors, with record_done on the
// single word that closes the record and last_result on the last word of a byte.
// Registers (delimiter, quoting, column select, mask, expected count) are written
// through the APB port at 8*index; the user must write them only while the block
// is idle; the block does not enforce it. A byte waits in the input stage, then
// its words go to the result register. Throughput: one byte per cycle while each
// byte yields at most one word and the receiver is ready; a byte with two words
// holds input while the two-entry result register drains one word per ready cycle.
// Reset clears the parser to field start, the counters to zero, the registers to
// their defaults (delimiter comma, quoting on, select all, empty mask, count 0)
// and empties the input and result stages.
// When the receiver stalls, results wait in the result register and one more
// byte waits in the input stage; then ready drops.

module csv_field_extractor
	import csvfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	csvfe_in_if.sink          bytes,
	csvfe_out_if.source       results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [7:0]        delim_q;
	logic              quote_en_q;
	logic              sel_all_q;
	logic [MASK_W-1:0] mask_q;
	logic [6:0]        expect_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	parse_st_t  st_q;
	result_t    res0_q;
	result_t    res1_q;
	logic [1:0] rcnt_q;

	logic       take;
	logic       room;
	logic       proc_fire;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	parse_st_t  nx;
	result_t    rv [2];
	logic [1:0] n;

	function automatic logic col_sel(logic [6:0] c, logic sa, logic [MASK_W-1:0] m);
		logic [MASK_W-1:0] ml;
		ml = m & COL_LIMIT;
		return sa || ((c < 7'(MASK_W)) && ml[c[5:0]]);
	endfunction

	// any selected column after this one
	function automatic logic more_cols(logic [6:0] c, logic [MASK_W-1:0] m);
		logic [MASK_W-1:0] ml;
		logic [7:0]        nxt;
		ml  = m & COL_LIMIT;
		nxt = {1'b0, c} + 8'd1;
		return (nxt < 8'(MASK_W)) && (|(ml >> nxt[5:0]));
	endfunction

	function automatic parse_st_t close_fld(parse_st_t s, logic sa, logic [MASK_W-1:0] m);
		parse_st_t r;
		logic      more;
		r    = s;
		more = sa || more_cols(s.col, m);
		if (s.fis && s.slot != CNT_MAX) r.slot = s.slot + 7'd1;
		if (s.col != CNT_MAX) r.col = s.col + 7'd1;
		r.phase = (s.fis && !more) ? PH_DONE : PH_START;
		r.fis   = 1'b0;
		return r;
	endfunction

	function automatic result_t mk_res(logic [1:0] k, logic [7:0] b, logic [1:0] code,
			parse_st_t s);
		result_t r;
		r.kind          = k;
		r.field_byte    = b;
		r.source_column = (s.col > COL_SAT) ? 6'd63 : s.col[5:0];
		r.output_slot   = (s.slot > SLOT_SAT) ? SLOT_SAT : s.slot;
		r.record_done   = 1'b0;
		r.error_code    = code;
		r.last_result   = 1'b0;
		return r;
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q    <= 8'd44;
			quote_en_q <= 1'b1;
			sel_all_q  <= 1'b1;
			mask_q     <= '0;
			expect_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DELIM:  delim_q    <= pwdata[7:0];
				REG_QUOTE:  quote_en_q <= pwdata[0];
				REG_SELALL: sel_all_q  <= pwdata[0];
				REG_MASK:   mask_q     <= pwdata[MASK_W-1:0];
				REG_EXPECT: expect_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DELIM:  prdata = DATA_W'(delim_q);
			REG_QUOTE:  prdata = DATA_W'(quote_en_q);
			REG_SELALL: prdata = DATA_W'(sel_all_q);
			REG_MASK:   prdata = DATA_W'(mask_q);
			REG_EXPECT: prdata = DATA_W'(expect_q);
			default:    prdata = '0;
		endcase
	end

	// handshake
	assign take      = (rcnt_q != 2'd0) && results.ready;
	assign room      = (rcnt_q == 2'd0) || (rcnt_q == 2'd1 && take);
	assign proc_fire = valid_s1 && room;
	assign bytes.ready = !valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.record_byte;
			last_s1 <= bytes.last_in_record;
		end
	end

	// parser: up to two words per byte
	always_comb begin
		logic       err;
		logic [1:0] code;
		logic       dclosed;
		logic       tail_end;
		logic       is_delim;
		logic       is_quote;
		logic       is_crlf;

		nx       = st_q;
		rv[0]    = '0;
		rv[1]    = '0;
		n        = 2'd0;
		err      = 1'b0;
		code     = ERR_UNQUOTED;
		dclosed  = 1'b0;
		tail_end = 1'b0;
		is_delim = (byte_s1 == delim_q);
		is_quote = (byte_s1 == CH_QUOTE);
		is_crlf  = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);

		case (st_q.phase)
			PH_START: begin
				if (is_crlf) begin
					nx = st_q;
				end else if (quote_en_q && is_quote) begin
					nx.fis   = col_sel(nx.col, sel_all_q, mask_q);
					nx.phase = PH_QUOTED;
					if (last_s1) begin
						err  = 1'b1;
						code = ERR_UNTERM;
					end
				end else if (is_delim) begin
					nx.fis = col_sel(nx.col, sel_all_q, mask_q);
					if (nx.fis) begin
						rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
						n = n + 2'd1;
					end
					nx      = close_fld(nx, sel_all_q, mask_q);
					dclosed = 1'b1;
				end else begin
					nx.fis   = col_sel(nx.col, sel_all_q, mask_q);
					nx.phase = PH_UNQUOTED;
					if (nx.fis) begin
						rv[n[0]] = mk_res(KIND_BYTE, byte_s1, ERR_UNQUOTED, nx);
						n = n + 2'd1;
					end
					if (last_s1) begin
						if (nx.fis) begin
							rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
							n = n + 2'd1;
						end
						nx = close_fld(nx, sel_all_q, mask_q);
					end
				end
			end
			PH_UNQUOTED: begin
				if (is_delim) begin
					if (nx.fis) begin
						rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
						n = n + 2'd1;
					end
					nx      = close_fld(nx, sel_all_q, mask_q);
					dclosed = 1'b1;
				end else if ((quote_en_q && is_quote) || is_crlf) begin
					err  = 1'b1;
					code = ERR_UNQUOTED;
				end else begin
					if (nx.fis) begin
						rv[n[0]] = mk_res(KIND_BYTE, byte_s1, ERR_UNQUOTED, nx);
						n = n + 2'd1;
					end
					if (last_s1) begin
						if (nx.fis) begin
							rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
							n = n + 2'd1;
						end
						nx = close_fld(nx, sel_all_q, mask_q);
					end
				end
			end
			PH_QUOTED: begin
				if (is_quote) begin
					nx.phase = PH_QUOTE_SEEN;
					if (last_s1) begin
						if (nx.fis) begin
							rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
							n = n + 2'd1;
						end
						nx = close_fld(nx, sel_all_q, mask_q);
					end
				end else if (last_s1) begin
					err  = 1'b1;
					code = ERR_UNTERM;
				end else if (nx.fis) begin
					rv[n[0]] = mk_res(KIND_BYTE, byte_s1, ERR_UNQUOTED, nx);
					n = n + 2'd1;
				end
			end
			PH_QUOTE_SEEN: begin
				if (is_delim) begin
					if (nx.fis) begin
						rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
						n = n + 2'd1;
					end
					nx      = close_fld(nx, sel_all_q, mask_q);
					dclosed = 1'b1;
				end else if (is_quote) begin
					if (last_s1) begin
						err  = 1'b1;
						code = ERR_UNTERM;
					end else begin
						// doubled quote stands for one quote
						if (nx.fis) begin
							rv[n[0]] = mk_res(KIND_BYTE, CH_QUOTE, ERR_UNQUOTED, nx);
							n = n + 2'd1;
						end
						nx.phase = PH_QUOTED;
					end
				end else begin
					err  = 1'b1;
					code = ERR_LONE_QUOTE;
				end
			end
			default: begin
				nx = st_q;
			end
		endcase

		if (err) begin
			rv[n[0]] = mk_res(KIND_ERR, 8'd0, code, nx);
			n = n + 2'd1;
			nx.phase = PH_ERROR;
		end

		if (last_s1) begin
			// trailing delimiter opens one more, empty field
			if (dclosed && nx.phase == PH_START) begin
				nx.fis = col_sel(nx.col, sel_all_q, mask_q);
				if (nx.fis) begin
					rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
					n = n + 2'd1;
				end
				nx = close_fld(nx, sel_all_q, mask_q);
			end
			if (!err) begin
				if (st_q.phase == PH_ERROR) begin
					rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
					n = n + 2'd1;
				end else begin
					tail_end = (n != 2'd0) && (rv[n[1]].kind == KIND_END);
					if (nx.slot != expect_q) begin
						if (tail_end) n = n - 2'd1;
						rv[n[0]] = mk_res(KIND_ERR, 8'd0, ERR_COUNT, nx);
						n = n + 2'd1;
					end else if (!tail_end) begin
						rv[n[0]] = mk_res(KIND_END, 8'd0, ERR_UNQUOTED, nx);
						n = n + 2'd1;
					end
				end
			end
			nx.phase = PH_START;
			nx.col   = '0;
			nx.slot  = '0;
			nx.fis   = 1'b0;
		end

		// n is one or two here, so n[1] picks the final word
		if (n != 2'd0) begin
			rv[n[1]].last_result = 1'b1;
			rv[n[1]].record_done = last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_START;
			st_q.col   <= '0;
			st_q.slot  <= '0;
			st_q.fis   <= 1'b0;
		end else if (proc_fire) begin
			st_q <= nx;
		end
	end

	// result register: two words, shown from the front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= 2'd0;
		end else if (proc_fire) begin
			rcnt_q <= n;
		end else if (take) begin
			rcnt_q <= rcnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire) begin
			res0_q <= rv[0];
			res1_q <= rv[1];
		end else if (take && rcnt_q == 2'd2) begin
			res0_q <= res1_q;
		end
	end

	assign results.valid         = (rcnt_q != 2'd0);
	assign results.kind          = res0_q.kind;
	assign results.field_byte    = res0_q.field_byte;
	assign results.source_column = res0_q.source_column;
	assign results.output_slot   = res0_q.output_slot;
	assign results.record_done   = res0_q.record_done;
	assign results.error_code    = res0_q.error_code;
	assign results.last_result   = res0_q.last_result;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q != 2'd3)
		else $error("result count out of range");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.record_done |-> results.last_result)
		else $error("record_done word is not the last word of its byte");

	a_record_reset: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire && last_s1 |=> st_q.col == 7'd0 && st_q.slot == 7'd0 && st_q.phase == PH_START)
		else $error("parser state not cleared after record end");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc_fire |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a waiting byte");

endmodule
